// ----- hw/rtl/gda_pkg.sv -----
// Shared types and constants for the Gregorian date arithmetic unit.
// No dependencies.
`default_nettype none
package gda_pkg;
    localparam int unsigned MONTHS_PER_YEAR = 12;
    localparam int unsigned MARCH_BASED_WRAP = 10;
    localparam int unsigned YEAR_SHIFT = 400;
    localparam int unsigned ERA_DAYS = 146097;
    localparam int unsigned YEAR_MIN = 1;
    localparam int unsigned YEAR_MAX = 9999;
    localparam int unsigned MONTH_BITS = 4;
    localparam int unsigned DAY_BITS = 5;
    localparam int unsigned OFFSET_BITS = 24;
    localparam int unsigned OUT_YEAR_BITS = 14;
    // Day numbers: years up to 2^16+400 fit below 2^25.
    localparam int unsigned SERIAL_BITS = 26;
    localparam int unsigned SUM_BITS = 27;
    localparam logic [SERIAL_BITS-1:0] SERIAL_LO = 26'd146403;   // 0001-01-01
    localparam logic [SERIAL_BITS-1:0] SERIAL_HI = 26'd3798461;  // 9999-12-31
    localparam logic signed [OFFSET_BITS-1:0] DIFF_MAX = 24'sh7FFFFF;
    localparam logic signed [OFFSET_BITS-1:0] DIFF_MIN = -24'sh800000;

    // Constant divisions as x / d == (x * RECIP) >> SHIFT, exact over the operand
    // ranges used: years below 2^16, day numbers below 2^22, days of an era.
    localparam logic [16:0] DIV100_RECIP = 17'd83887;
    localparam int unsigned DIV100_SHIFT = 23;
    localparam logic [22:0] ERA_RECIP = 23'd7525902;
    localparam int unsigned ERA_SHIFT = 40;
    localparam logic [17:0] DIV1460_RECIP = 18'd183860;
    localparam int unsigned DIV1460_SHIFT = 28;
    localparam logic [17:0] DIV365_RECIP = 18'd183860;
    localparam int unsigned DIV365_SHIFT = 26;
    localparam logic [11:0] MP_RECIP = 12'd3427;
    localparam int unsigned MP_SHIFT = 19;

    typedef logic [DAY_BITS-1:0] t_day;
    typedef logic [MONTH_BITS-1:0] t_month;
    typedef logic [SERIAL_BITS-1:0] t_serial;

    // Days before the start of each March-based month (0 = March).
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] r;
        case (mp)
            4'd0: r = 9'd0;    4'd1: r = 9'd31;   4'd2: r = 9'd61;
            4'd3: r = 9'd92;   4'd4: r = 9'd122;  4'd5: r = 9'd153;
            4'd6: r = 9'd184;  4'd7: r = 9'd214;  4'd8: r = 9'd245;
            4'd9: r = 9'd275;  4'd10: r = 9'd306; 4'd11: r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] month_len(input t_month m, input logic leap);
        logic [4:0] r;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
            4'd2: r = leap ? 5'd29 : 5'd28;
            default: r = 5'd0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/gda_if.sv -----
// Valid/ready channel carrying one payload struct.
// No dependencies.
`default_nettype none
interface gda_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/gda_serial.sv -----
// Date to day number, two register stages, with month/day check.
// Depends on gda_pkg.
`default_nettype none
module gda_serial
    import gda_pkg::*;
#(
    parameter int YEAR_BITS = 14
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic [YEAR_BITS-1:0] i_year,
    input  wire t_month               i_month,
    input  wire t_day                 i_day,
    output t_serial                   o_serial,
    output logic                      o_valid
);
    localparam int YS_BITS = YEAR_BITS + 1;
    localparam int PROD_BITS = YEAR_BITS + 17;
    logic [YS_BITS-1:0] n_ys, r_ys;
    logic [YS_BITS-1:0] n_c, r_c;
    logic [8:0] n_doy, r_doy;
    logic n_ok, r_ok, r_ok2;
    logic [3:0] mp;
    logic [PROD_BITS-1:0] cent_prod;
    logic [YEAR_BITS-1:0] cent;
    logic hund, early;
    logic leap;
    t_serial r_serial;
    logic [SERIAL_BITS-1:0] yd;

    always_comb begin
        cent_prod = PROD_BITS'(i_year) * PROD_BITS'(DIV100_RECIP);
        cent = YEAR_BITS'(cent_prod >> DIV100_SHIFT);
        hund = i_year == cent * YEAR_BITS'(100);
        leap = (i_year[1:0] == 2'b00 && !hund) || (hund && cent[1:0] == 2'b00);
        early = i_month <= 4'd2;
        n_ok = i_month >= 4'd1 && i_month <= 4'(MONTHS_PER_YEAR) && i_day != '0
            && i_day <= month_len(i_month, leap);
        n_ys = YS_BITS'(i_year) + YS_BITS'(YEAR_SHIFT) - YS_BITS'(early);
        // Centuries of the shifted year; borrow only when a March-based year wraps one.
        n_c = YS_BITS'(cent) + YS_BITS'(YEAR_SHIFT / 100) - YS_BITS'(early && hund);
        mp = early ? i_month + 4'd9 : i_month - 4'd3;
        n_doy = month_start(mp) + 9'(i_day) - 9'd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ys <= n_ys;
            r_c <= n_c;
            r_doy <= n_doy;
            r_ok <= n_ok;
            r_serial <= yd;
            r_ok2 <= r_ok;
        end
    end

    always_comb begin
        yd = SERIAL_BITS'(r_ys) * SERIAL_BITS'(365) + SERIAL_BITS'(r_ys >> 2)
            - SERIAL_BITS'(r_c) + SERIAL_BITS'(r_c >> 2) + SERIAL_BITS'(r_doy);
    end

    assign o_serial = r_serial;
    assign o_valid = r_ok2;
endmodule
`default_nettype wire

// ----- hw/rtl/gda_civil.sv -----
// Day number back to date, six register stages.
// Depends on gda_pkg.
`default_nettype none
module gda_civil
    import gda_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_en,
    input  wire t_serial i_serial,
    output logic [OUT_YEAR_BITS-1:0] o_year,
    output t_month     o_month,
    output t_day       o_day
);
    logic [44:0] era_prod;
    logic [4:0] n_era, r_era1, r_era2, r_era3, r_era4;
    logic [21:0] r_z1;
    logic [17:0] n_doe, r_doe2, r_doe3, r_doe4;
    logic [35:0] q1460_prod;
    logic [6:0] q1460;
    logic [2:0] q36;
    logic [17:0] n_t, r_t3;
    logic [35:0] yoe_prod;
    logic [8:0] n_yoe, r_yoe4;
    logic [1:0] c100;
    logic [8:0] n_doy, r_doy5;
    logic [14:0] n_ybase, r_ybase5;
    logic [10:0] mp_num;
    logic [22:0] mp_prod;
    logic [3:0] n_mp;
    logic [13:0] r_y;
    t_month r_m;
    t_day r_d;

    always_comb begin
        era_prod = 45'(i_serial[21:0]) * 45'(ERA_RECIP);
        n_era = 5'(era_prod >> ERA_SHIFT);
        n_doe = 18'(r_z1 - 22'(r_era1) * 22'(ERA_DAYS));
    end

    // Years of era: the 4-year, century and era corrections ahead of the divide by 365.
    always_comb begin
        q1460_prod = 36'(r_doe2) * 36'(DIV1460_RECIP);
        q1460 = 7'(q1460_prod >> DIV1460_SHIFT);
        q36 = 3'(r_doe2 >= 18'd36524) + 3'(r_doe2 >= 18'd73048)
            + 3'(r_doe2 >= 18'd109572) + 3'(r_doe2 >= 18'd146096);
        n_t = r_doe2 - 18'(q1460) + 18'(q36) - 18'(r_doe2 == 18'd146096);
        yoe_prod = 36'(r_t3) * 36'(DIV365_RECIP);
        n_yoe = 9'(yoe_prod >> DIV365_SHIFT);
    end

    always_comb begin
        c100 = 2'(r_yoe4 >= 9'd100) + 2'(r_yoe4 >= 9'd200) + 2'(r_yoe4 >= 9'd300);
        n_doy = 9'(r_doe4 - (18'(r_yoe4) * 18'd365 + 18'(r_yoe4 >> 2) - 18'(c100)));
        n_ybase = 15'(r_yoe4) + 15'(r_era4) * 15'd400 - 15'(YEAR_SHIFT);
        mp_num = 11'(r_doy5) * 11'd5 + 11'd2;
        mp_prod = 23'(mp_num) * 23'(MP_RECIP);
        n_mp = 4'(mp_prod >> MP_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z1 <= i_serial[21:0];
            r_era1 <= n_era;
            r_doe2 <= n_doe;
            r_era2 <= r_era1;
            r_t3 <= n_t;
            r_doe3 <= r_doe2;
            r_era3 <= r_era2;
            r_yoe4 <= n_yoe;
            r_doe4 <= r_doe3;
            r_era4 <= r_era3;
            r_doy5 <= n_doy;
            r_ybase5 <= n_ybase;
            r_m <= (n_mp < 4'(MARCH_BASED_WRAP)) ? n_mp + 4'd3 : n_mp - 4'd9;
            r_d <= 5'(r_doy5 - month_start(n_mp) + 9'd1);
            r_y <= 14'(r_ybase5 + 15'(n_mp >= 4'(MARCH_BASED_WRAP)));
        end
    end

    assign o_year = r_y;
    assign o_month = r_m;
    assign o_day = r_d;
endmodule
`default_nettype wire

// ----- hw/rtl/gregorian_date_arithmetic_unit.sv -----
// Top level: converts both dates, adds offset, converts back, differences.
// Depends on gda_pkg, gda_if, gda_serial, gda_civil.
//
// Channel  Dir  Payload
// i_in     in   year_a month_a day_a day_offset year_b month_b day_b
// o_out    out  shifted date, day_difference, compare and valid flags
//
// One item per cycle while o_out is not stalled; the stages are the day-number
// conversion, the add/clamp stage and the date rebuild, in that order.
// Reset clears the valid bits only. A stall on o_out freezes every stage.
`default_nettype none
module gregorian_date_arithmetic_unit
    import gda_pkg::*;
#(
    parameter int YEAR_BITS = 14
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    gda_if.sink       i_in,
    gda_if.source     o_out
);
    localparam int LAT = 9;
    localparam int CIV_LAT = 6;
    logic en;
    logic [LAT-1:0] r_v;
    t_serial sa, sb;
    logic av, bv;
    logic [1:0][OFFSET_BITS-1:0] r_off;
    logic [LAT-1:0] r_bef, r_eq;
    logic a_first, equal;
    logic signed [SUM_BITS-1:0] z, dd;
    t_serial r_z;
    logic r_av3, r_bv3, r_ovf3, r_hi3;
    logic signed [OFFSET_BITS-1:0] r_diff3;
    logic [CIV_LAT-1:0][OFFSET_BITS-1:0] r_diffp;
    logic [CIV_LAT-1:0] r_avp, r_bvp, r_ovfp, r_hip;
    logic [OUT_YEAR_BITS-1:0] cy;
    t_month cm;
    t_day cd;

    assign en = o_out.ready || !r_v[LAT-1];
    assign i_in.ready = en;

    always_comb begin
        if (i_in.data.year_a != i_in.data.year_b) a_first = i_in.data.year_a < i_in.data.year_b;
        else if (i_in.data.month_a != i_in.data.month_b)
            a_first = i_in.data.month_a < i_in.data.month_b;
        else a_first = i_in.data.day_a < i_in.data.day_b;
        equal = i_in.data.year_a == i_in.data.year_b
            && i_in.data.month_a == i_in.data.month_b && i_in.data.day_a == i_in.data.day_b;
    end

    gda_serial #(.YEAR_BITS(YEAR_BITS)) u_sa (.i_clk, .i_en(en), .i_year(i_in.data.year_a),
        .i_month(i_in.data.month_a), .i_day(i_in.data.day_a), .o_serial(sa), .o_valid(av));
    gda_serial #(.YEAR_BITS(YEAR_BITS)) u_sb (.i_clk, .i_en(en), .i_year(i_in.data.year_b),
        .i_month(i_in.data.month_b), .i_day(i_in.data.day_b), .o_serial(sb), .o_valid(bv));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[LAT-2:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_off <= {r_off[0], i_in.data.day_offset};
            r_bef <= {r_bef[LAT-2:0], a_first};
            r_eq <= {r_eq[LAT-2:0], equal};
        end
    end

    always_comb begin
        z = $signed({1'b0, sa}) + SUM_BITS'($signed(r_off[1]));
        dd = $signed({1'b0, sa}) - $signed({1'b0, sb});
    end

    // Stage 3: add offset, clamp to the supported range, saturate the difference.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_av3 <= av;
            r_bv3 <= bv;
            r_ovf3 <= z < $signed({1'b0, SERIAL_LO}) || z > $signed({1'b0, SERIAL_HI});
            r_hi3 <= z > $signed({1'b0, SERIAL_HI});
            r_z <= (z < $signed({1'b0, SERIAL_LO}) || z > $signed({1'b0, SERIAL_HI}))
                ? SERIAL_LO : SERIAL_BITS'(z);
            if (dd > SUM_BITS'(DIFF_MAX)) r_diff3 <= DIFF_MAX;
            else if (dd < SUM_BITS'(DIFF_MIN)) r_diff3 <= DIFF_MIN;
            else r_diff3 <= OFFSET_BITS'(dd);
            r_diffp <= {r_diffp[CIV_LAT-2:0], r_diff3};
            r_avp <= {r_avp[CIV_LAT-2:0], r_av3};
            r_bvp <= {r_bvp[CIV_LAT-2:0], r_bv3};
            r_ovfp <= {r_ovfp[CIV_LAT-2:0], r_ovf3};
            r_hip <= {r_hip[CIV_LAT-2:0], r_hi3};
        end
    end

    gda_civil u_civ (.i_clk, .i_en(en), .i_serial(r_z), .o_year(cy), .o_month(cm),
        .o_day(cd));

    always_comb begin
        o_out.valid = r_v[LAT-1];
        o_out.data.a_before_b = r_bef[LAT-1];
        o_out.data.a_equals_b = r_eq[LAT-1];
        o_out.data.a_valid = r_avp[CIV_LAT-1];
        o_out.data.b_valid = r_bvp[CIV_LAT-1];
        o_out.data.year_overflow = r_avp[CIV_LAT-1] && r_ovfp[CIV_LAT-1];
        o_out.data.day_difference = (r_avp[CIV_LAT-1] && r_bvp[CIV_LAT-1])
            ? r_diffp[CIV_LAT-1] : '0;
        if (!r_avp[CIV_LAT-1]) begin
            o_out.data.shifted_year = '0;
            o_out.data.shifted_month = '0;
            o_out.data.shifted_day = '0;
        end else if (r_hip[CIV_LAT-1]) begin
            o_out.data.shifted_year = OUT_YEAR_BITS'(YEAR_MAX);
            o_out.data.shifted_month = 4'(MONTHS_PER_YEAR);
            o_out.data.shifted_day = 5'd31;
        end else begin
            o_out.data.shifted_year = cy;
            o_out.data.shifted_month = cm;
            o_out.data.shifted_day = cd;
        end
    end
endmodule
`default_nettype wire
